/* rtl/fpcr_pkg.sv */
// Shared types and codes for the framed packet CRC receiver.
package fpcr_pkg;

    localparam logic [1:0] ST_BUSY    = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_CRC_ERR = 2'd2;
    localparam logic [1:0] ST_FMT_ERR = 2'd3;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_VERSION     = 2'd2;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  protocol_version;
        logic [15:0] max_payload_length;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_offset;
        logic        payload_last;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic [15:0] frame_sequence;
        logic [15:0] frame_crc;
    } t_result;

endpackage

/* rtl/fpcr_cfg.sv */
// Configuration registers of the framed packet CRC receiver.
module fpcr_cfg
    import fpcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first         <= 8'hAA;
            r_cfg.sync_second        <= 8'h55;
            r_cfg.protocol_version   <= 8'h01;
            r_cfg.max_payload_length <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:  r_cfg.sync_first         <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second        <= i_cfg_data[7:0];
                CFG_VERSION:     r_cfg.protocol_version   <= i_cfg_data[7:0];
                CFG_MAX_LENGTH:  r_cfg.max_payload_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/fpcr_crc_byte.sv */
// One-byte CRC-16 update, MSB first, polynomial 0x1021.
module fpcr_crc_byte
    import fpcr_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

/* rtl/fpcr_parser.sv */
// Frame parser state and per-word result logic.
module fpcr_parser
    import fpcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_VERSION = 4'd2;
    localparam logic [3:0] PH_TYPE    = 4'd3;
    localparam logic [3:0] PH_LEN_HI  = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_SEQ_HI  = 4'd6;
    localparam logic [3:0] PH_SEQ_LO  = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_CRC_HI  = 4'd9;
    localparam logic [3:0] PH_CRC_LO  = 4'd10;

    logic [3:0]  r_phase,    n_phase;
    logic [15:0] r_crc,      n_crc;
    logic [15:0] r_check,    n_check;
    logic [15:0] r_count,    n_count;
    logic [15:0] r_length,   n_length;
    logic [15:0] r_sequence, n_sequence;
    logic [7:0]  r_type,     n_type;

    logic [15:0] fed_crc;
    logic [16:0] next_offset;

    fpcr_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (fed_crc)
    );

    assign next_offset = {1'b0, r_count} + 17'd1;

    always_comb begin
        n_phase    = r_phase;
        n_crc      = r_crc;
        n_check    = r_check;
        n_count    = r_count;
        n_length   = r_length;
        n_sequence = r_sequence;
        n_type     = r_type;

        o_result                = '0;
        o_result.status         = ST_BUSY;

        unique case (r_phase)
            PH_SYNC1: begin
                if (i_byte == i_cfg.sync_first) n_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    n_crc   = CRC_INIT;
                    n_check = '0;
                    n_phase = PH_VERSION;
                end else if (i_byte != i_cfg.sync_first) begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_VERSION: begin
                n_crc = fed_crc;
                if (i_byte != i_cfg.protocol_version) begin
                    n_phase         = PH_SYNC1;
                    o_result.status = ST_FMT_ERR;
                end else begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_type  = i_byte;
                n_crc   = fed_crc;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_length = {i_byte, 8'h00};
                n_crc    = fed_crc;
                n_phase  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_length = {r_length[15:8], i_byte};
                n_crc    = fed_crc;
                if (n_length > i_cfg.max_payload_length) begin
                    n_phase         = PH_SYNC1;
                    o_result.status = ST_FMT_ERR;
                end else begin
                    n_phase = PH_SEQ_HI;
                end
            end
            PH_SEQ_HI: begin
                n_sequence = {i_byte, 8'h00};
                n_crc      = fed_crc;
                n_phase    = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                n_sequence = {r_sequence[15:8], i_byte};
                n_crc      = fed_crc;
                n_count    = '0;
                n_phase    = (r_length == 16'd0) ? PH_CRC_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc                   = fed_crc;
                n_count                 = next_offset[15:0];
                o_result.payload_valid  = 1'b1;
                o_result.payload_byte   = i_byte;
                o_result.payload_offset = r_count;
                if (next_offset >= {1'b0, r_length}) begin
                    o_result.payload_last = 1'b1;
                    n_phase               = PH_CRC_HI;
                end
            end
            PH_CRC_HI: begin
                n_check = {i_byte, 8'h00};
                n_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_check         = {r_check[15:8], i_byte};
                n_phase         = PH_SYNC1;
                o_result.status = (r_crc == n_check) ? ST_READY : ST_CRC_ERR;
            end
            default: begin
                n_phase         = PH_SYNC1;
                o_result.status = ST_FMT_ERR;
            end
        endcase

        o_result.frame_type     = n_type;
        o_result.frame_length   = n_length;
        o_result.frame_sequence = n_sequence;
        o_result.frame_crc      = n_check;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_crc      <= CRC_INIT;
            r_check    <= '0;
            r_count    <= '0;
            r_length   <= '0;
            r_sequence <= '0;
            r_type     <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_crc      <= n_crc;
            r_check    <= n_check;
            r_count    <= n_count;
            r_length   <= n_length;
            r_sequence <= n_sequence;
            r_type     <= n_type;
        end
    end

    a_payload_phase_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.payload_valid |=> (r_phase == PH_PAYLOAD || r_phase == PH_CRC_HI))
        else $error("payload word left parser in wrong phase");

    a_crc_reseeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_SYNC2 && i_byte == i_cfg.sync_second
        |=> r_crc == CRC_INIT && r_check == 16'd0)
        else $error("crc not reseeded on sync");

    a_step_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_crc) && $stable(r_count))
        else $error("parser state moved without a word");

endmodule

/* rtl/framed_packet_crc_receiver_core.sv */
// Top level of the framed packet CRC receiver: word registers around the parser.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_rx_byte
//  out     | output    | o_out_valid / i_out_stall | status, payload and frame fields
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; a taken word
// lands in the input register, and the parser steps it from there into the
// result register.
// The byte-wide CRC update and the phase step set the path from the input register to the result register.
// Reset is synchronous, active low, and restores the register defaults.
// A stalled result holds; the input register keeps taking words until it is full.
module framed_packet_crc_receiver_core
    import fpcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_payload_offset,
    output logic        o_payload_last,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_frame_sequence,
    output logic [15:0] o_frame_crc,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    cfg;
    t_result step_result;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       advance;

    fpcr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fpcr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_payload_valid  = r_out.payload_valid;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_payload_offset = r_out.payload_offset;
    assign o_payload_last   = r_out.payload_last;
    assign o_frame_type     = r_out.frame_type;
    assign o_frame_length   = r_out.frame_length;
    assign o_frame_sequence = r_out.frame_sequence;
    assign o_frame_crc      = r_out.frame_crc;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("word registers not empty after reset");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out_valid)
        else $error("parser step lost its result");

    a_stall_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(r_out))
        else $error("stalled result changed");

    a_end_not_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_READY || o_status == ST_CRC_ERR)
        |-> !o_payload_valid)
        else $error("frame end flagged on a payload word");

endmodule

/* dv/fpcr_frame_checker.sv */
// Frame checker: watches the byte, config and result channels, predicts each result word and compares.
module fpcr_frame_checker
    import fpcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_result     i_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked,
    output int          o_ready,
    output int          o_crc_errors,
    output int          o_format_errors
);

    typedef enum logic [3:0] {
        PH_HUNT_FIRST,
        PH_HUNT_SECOND,
        PH_VERSION,
        PH_TYPE,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SEQ_HI,
        PH_SEQ_LO,
        PH_PAYLOAD,
        PH_CHECK_HI,
        PH_CHECK_LO
    } t_phase;

    t_cfg        cfg;
    t_phase      phase;
    logic [15:0] crc_acc;
    logic [15:0] check_rx;
    logic [15:0] payload_count;
    logic [15:0] length_rx;
    logic [15:0] sequence_rx;
    logic [7:0]  type_rx;
    t_result     status_q[$];
    t_result     want;
    int          mismatches;
    int          checked;
    int          ready_count;
    int          crc_err_count;
    int          fmt_err_count;

    function automatic logic [15:0] fold_crc(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.status = ST_BUSY;
        case (phase)
            PH_HUNT_FIRST: begin
                if (b == cfg.sync_first) phase = PH_HUNT_SECOND;
            end
            PH_HUNT_SECOND: begin
                if (b == cfg.sync_second) begin
                    crc_acc  = CRC_INIT;
                    check_rx = '0;
                    phase    = PH_VERSION;
                end else if (b != cfg.sync_first) begin
                    phase = PH_HUNT_FIRST;
                end
            end
            PH_VERSION: begin
                crc_acc = fold_crc(crc_acc, b);
                if (b != cfg.protocol_version) begin
                    phase    = PH_HUNT_FIRST;
                    r.status = ST_FMT_ERR;
                end else begin
                    phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_rx = b;
                crc_acc = fold_crc(crc_acc, b);
                phase   = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_rx = {b, 8'h00};
                crc_acc   = fold_crc(crc_acc, b);
                phase     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_rx = length_rx | {8'h00, b};
                crc_acc   = fold_crc(crc_acc, b);
                if (length_rx > cfg.max_payload_length) begin
                    phase    = PH_HUNT_FIRST;
                    r.status = ST_FMT_ERR;
                end else begin
                    phase = PH_SEQ_HI;
                end
            end
            PH_SEQ_HI: begin
                sequence_rx = {b, 8'h00};
                crc_acc     = fold_crc(crc_acc, b);
                phase       = PH_SEQ_LO;
            end
            PH_SEQ_LO: begin
                sequence_rx   = sequence_rx | {8'h00, b};
                crc_acc       = fold_crc(crc_acc, b);
                payload_count = '0;
                phase         = (length_rx == 16'd0) ? PH_CHECK_HI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc          = fold_crc(crc_acc, b);
                r.payload_valid  = 1'b1;
                r.payload_byte   = b;
                r.payload_offset = payload_count;
                payload_count    = payload_count + 16'd1;
                if ({1'b0, r.payload_offset} + 17'd1 >= {1'b0, length_rx}) begin
                    r.payload_last = 1'b1;
                    phase          = PH_CHECK_HI;
                end
            end
            PH_CHECK_HI: begin
                check_rx = {b, 8'h00};
                phase    = PH_CHECK_LO;
            end
            PH_CHECK_LO: begin
                check_rx = check_rx | {8'h00, b};
                phase    = PH_HUNT_FIRST;
                r.status = (crc_acc == check_rx) ? ST_READY : ST_CRC_ERR;
            end
            default: begin
                phase    = PH_HUNT_FIRST;
                r.status = ST_FMT_ERR;
            end
        endcase
        r.frame_type     = type_rx;
        r.frame_length   = length_rx;
        r.frame_sequence = sequence_rx;
        r.frame_crc      = check_rx;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] got_val);
        if (exp_val !== got_val) begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
        end
    endtask

    task automatic compare_result(input t_result exp_r, input t_result got_r);
        compare_field("status", 16'(exp_r.status), 16'(got_r.status));
        compare_field("payload_valid", 16'(exp_r.payload_valid), 16'(got_r.payload_valid));
        compare_field("payload_byte", 16'(exp_r.payload_byte), 16'(got_r.payload_byte));
        compare_field("payload_offset", exp_r.payload_offset, got_r.payload_offset);
        compare_field("payload_last", 16'(exp_r.payload_last), 16'(got_r.payload_last));
        compare_field("frame_type", 16'(exp_r.frame_type), 16'(got_r.frame_type));
        compare_field("frame_length", exp_r.frame_length, got_r.frame_length);
        compare_field("frame_sequence", exp_r.frame_sequence, got_r.frame_sequence);
        compare_field("frame_crc", exp_r.frame_crc, got_r.frame_crc);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg           = '{8'hAA, 8'h55, 8'h01, 16'd256};
            phase         = PH_HUNT_FIRST;
            crc_acc       = CRC_INIT;
            check_rx      = '0;
            payload_count = '0;
            length_rx     = '0;
            sequence_rx   = '0;
            type_rx       = '0;
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:  cfg.sync_first         = i_cfg_data[7:0];
                    CFG_SYNC_SECOND: cfg.sync_second        = i_cfg_data[7:0];
                    CFG_VERSION:     cfg.protocol_version   = i_cfg_data[7:0];
                    CFG_MAX_LENGTH:  cfg.max_payload_length = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none got status %0h", $time,
                             i_result.status);
                end else begin
                    want = status_q.pop_front();
                    checked++;
                    case (want.status)
                        ST_READY:   ready_count++;
                        ST_CRC_ERR: crc_err_count++;
                        ST_FMT_ERR: fmt_err_count++;
                        default: ;
                    endcase
                    compare_result(want, i_result);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(parse_byte(i_rx_byte));
            end
        end
        o_mismatches    <= mismatches;
        o_pending       <= status_q.size();
        o_checked       <= checked;
        o_ready         <= ready_count;
        o_crc_errors    <= crc_err_count;
        o_format_errors <= fmt_err_count;
    end

endmodule

/* dv/tb_framed_packet_crc_receiver_core.sv */
// Testbench top for the framed packet CRC receiver: byte stimulus, idling, output stalls and verdict.
module tb_framed_packet_crc_receiver_core;
    import fpcr_pkg::*;

    localparam int RUN_LIMIT       = 200000;
    localparam int BYTES_PER_PHASE = 450;
    localparam int DRAIN_CYCLES    = 4;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_SYNC_FIRST;
    logic [15:0] cfg_data  = '0;

    logic [1:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic        payload_last;
    logic [7:0]  frame_type;
    logic [15:0] frame_length;
    logic [15:0] frame_sequence;
    logic [15:0] frame_crc;
    t_result     dut_result;

    int          mismatches;
    int          pending;
    int          checked;
    int          ready_count;
    int          crc_err_count;
    int          fmt_err_count;
    int          cycle_count = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    int          bytes_sent  = 0;
    t_cfg        link_cfg;
    logic [7:0]  frame_q[$];

    assign dut_result = {status, payload_valid, payload_byte, payload_offset, payload_last,
                         frame_type, frame_length, frame_sequence, frame_crc};

    framed_packet_crc_receiver_core DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_status         (status),
        .o_payload_valid  (payload_valid),
        .o_payload_byte   (payload_byte),
        .o_payload_offset (payload_offset),
        .o_payload_last   (payload_last),
        .o_frame_type     (frame_type),
        .o_frame_length   (frame_length),
        .o_frame_sequence (frame_sequence),
        .o_frame_crc      (frame_crc),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    fpcr_frame_checker u_frame_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_result        (dut_result),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_ready         (ready_count),
        .o_crc_errors    (crc_err_count),
        .o_format_errors (fmt_err_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] advance_crc(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic offer_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_queued();
        while (frame_q.size() > 0) offer_byte(frame_q.pop_front());
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input t_cfg c);
        link_cfg  = c;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= {8'h00, c.sync_first};
        @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= {8'h00, c.sync_second};
        @(posedge clk);
        cfg_index <= CFG_VERSION;
        cfg_data  <= {8'h00, c.protocol_version};
        @(posedge clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= c.max_payload_length;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic start_phase(input int ph);
        case (ph)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
                load_config('{8'hAA, 8'h55, 8'h01, 16'd256});
            end
            1: begin
                idle_pct  = 58;
                stall_pct = 0;
                load_config('{8'h00, 8'hFF, 8'hFF, 16'd0});
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 58;
                load_config('{8'hFF, 8'h00, 8'h00, 16'hFFFF});
            end
            default: begin
                idle_pct  = 15;
                stall_pct = 15;
                load_config('{8'h7E, 8'h7E, 8'($urandom), 16'($urandom_range(40, 1))});
            end
        endcase
    endtask

    // cut_at < 0 sends the whole frame, else only that many bytes after the sync pair
    task automatic queue_frame(input logic [7:0] version, input logic [15:0] length,
                               input bit bad_crc, input int cut_at, input int extra_sync);
        logic [7:0]  body[$];
        logic [15:0] crc;
        logic [15:0] seq;
        int          i;
        seq = 16'($urandom);
        body.push_back(version);
        body.push_back(8'($urandom));
        body.push_back(length[15:8]);
        body.push_back(length[7:0]);
        body.push_back(seq[15:8]);
        body.push_back(seq[7:0]);
        for (i = 0; i < int'(length) && (cut_at < 0 || body.size() < cut_at); i++) begin
            body.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        foreach (body[k]) crc = advance_crc(crc, body[k]);
        if (bad_crc) crc ^= (16'd1 << $urandom_range(15));
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        repeat (extra_sync) frame_q.push_back(link_cfg.sync_first);
        frame_q.push_back(link_cfg.sync_first);
        frame_q.push_back(link_cfg.sync_second);
        for (i = 0; i < body.size() && (cut_at < 0 || i < cut_at); i++) begin
            frame_q.push_back(body[i]);
        end
    endtask

    task automatic queue_random_traffic();
        int          pick;
        int          lim;
        int          extra;
        int          i;
        logic [15:0] length;
        logic [7:0]  bad_version;
        pick = $urandom_range(99);
        lim  = (link_cfg.max_payload_length < 16'd12) ? int'(link_cfg.max_payload_length) : 12;
        if ($urandom_range(99) < 4) begin
            lim = (link_cfg.max_payload_length < 16'd300) ?
                  int'(link_cfg.max_payload_length) : 300;
        end
        length = 16'($urandom_range(lim));
        extra  = 0;
        if (link_cfg.sync_first != link_cfg.sync_second && $urandom_range(99) < 15) begin
            extra = $urandom_range(3, 1);
        end
        if (pick < 65) begin
            queue_frame(link_cfg.protocol_version, length, 1'b0, -1, extra);
        end else if (pick < 75) begin
            queue_frame(link_cfg.protocol_version, length, 1'b1, -1, extra);
        end else if (pick < 80) begin
            bad_version = link_cfg.protocol_version ^ 8'($urandom_range(255, 1));
            queue_frame(bad_version, length, 1'b0, -1, extra);
        end else if (pick < 86 && link_cfg.max_payload_length != 16'hFFFF) begin
            if ($urandom_range(4) == 0 || link_cfg.max_payload_length > 16'd65000) begin
                length = 16'hFFFF;
            end else begin
                length = link_cfg.max_payload_length + 16'($urandom_range(500, 1));
            end
            queue_frame(link_cfg.protocol_version, length, 1'b0, 4, extra);
        end else if (pick < 92) begin
            queue_frame(link_cfg.protocol_version, length, 1'b0,
                        $urandom_range(int'(length) + 7), extra);
        end else begin
            for (i = 0; i < $urandom_range(8, 1); i++) begin
                frame_q.push_back(($urandom_range(99) < 30) ? link_cfg.sync_first
                                                             : 8'($urandom));
            end
        end
    endtask

    initial begin
        int ph;
        int phase_goal;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (ph = 0; ph < 4; ph++) begin
            start_phase(ph);
            if (ph == 0) begin
                frame_q.push_back(8'h00);
                frame_q.push_back(8'hFF);
                queue_frame(8'h01, 16'd0, 1'b0, -1, 1);
                queue_frame(8'h02, 16'd0, 1'b0, 1, 0);
                queue_frame(8'h01, 16'h0101, 1'b0, 4, 0);
                send_queued();
            end
            phase_goal = bytes_sent + BYTES_PER_PHASE;
            while (bytes_sent < phase_goal) begin
                queue_random_traffic();
                send_queued();
            end
            drain();
        end
        $display("Fed %0d bytes through four register settings and four idle/stall mixes.",
                 bytes_sent);
        $display("Compared %0d result words: %0d ready, %0d CRC errors, %0d format errors.",
                 checked, ready_count, crc_err_count, fmt_err_count);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/fpcr_pkg.sv
rtl/fpcr_cfg.sv
rtl/fpcr_crc_byte.sv
rtl/fpcr_parser.sv
rtl/framed_packet_crc_receiver_core.sv
dv/fpcr_frame_checker.sv
dv/tb_framed_packet_crc_receiver_core.sv
